>>> sv/hvps_pkg.sv
// ----------------------------------------------------------------------------
// hvps_pkg
// Shared types and constants for the HV precharge sequencer.
// ----------------------------------------------------------------------------
package hvps_pkg;

	localparam int RATIO_W  = 10;
	localparam int TIME_W   = 16;
	localparam int DELTA_W  = 10;
	localparam int VOLT_W   = 16;
	localparam int MODE_W   = 3;
	localparam int PROD_W   = RATIO_W + VOLT_W;
	localparam int IN_W     = 48;
	localparam int OUT_W    = 8;
	localparam int ADDR_W   = 3;
	localparam int DATA_W   = 32;

	localparam logic [RATIO_W-1:0] RATIO_RESET  = 10'd850;
	localparam logic [TIME_W-1:0]  VERIFY_RESET = 16'd5000;

	localparam logic [MODE_W-1:0] MODE_IDLE          = 3'd0;
	localparam logic [MODE_W-1:0] MODE_PRECHARGE     = 3'd1;
	localparam logic [MODE_W-1:0] MODE_ENERGIZED     = 3'd2;
	localparam logic [MODE_W-1:0] MODE_CHG_PRECHARGE = 3'd3;
	localparam logic [MODE_W-1:0] MODE_CHARGING      = 3'd4;

	localparam logic REG_RATIO  = 1'b0;
	localparam logic REG_VERIFY = 1'b1;

	typedef struct packed {
		logic [RATIO_W-1:0] precharge_ratio;
		logic [TIME_W-1:0]  verify_time_ms;
	} cfg_t;

	typedef struct packed {
		logic [VOLT_W-1:0]  pack_voltage;
		logic [VOLT_W-1:0]  tractive_voltage;
		logic [DELTA_W-1:0] delta_ms;
		logic               charger_present;
		logic               hv_ok;
		logic               shutdown_closed;
	} item_t;

	typedef struct packed {
		logic               precharge_contactor;
		logic               drive_contactor;
		logic [MODE_W-1:0]  mode;
	} result_t;

endpackage

>>> sv/hv_precharge_sequencer.sv
// ----------------------------------------------------------------------------
// hv_precharge_sequencer
// Precharge and contactor sequencer for a traction battery, one tick per item.
// ----------------------------------------------------------------------------
// channel  dir  handshake         payload
// s_*      in   tvalid/tready     tdata: tick flags, delta_ms, voltages
// m_*      out  tvalid/tready     tdata: mode, drive, precharge contactors
// apb      in   psel/penable      precharge_ratio @0x0, verify_time_ms @0x4
//
// one tick per clock sustained while the output is not stalled; input register
// then result register, with the multiply-compare and the state update sitting
// between the two registers.
// reset clears mode, timer and contactors and loads the register defaults.
// a stalled result holds in the output register while the input register
// still takes one more tick.
// ----------------------------------------------------------------------------
module hv_precharge_sequencer (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	// [0] shutdown_closed, [1] hv_ok, [2] charger_present, [12:3] delta_ms,
	// [28:13] tractive_voltage, [44:29] pack_voltage, [47:45] zero
	input  logic [hvps_pkg::IN_W-1:0]   s_tdata,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// [2:0] mode, [3] drive_contactor, [4] precharge_contactor, [7:5] zero
	output logic [hvps_pkg::OUT_W-1:0]  m_tdata,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [hvps_pkg::ADDR_W-1:0] paddr,
	input  logic [hvps_pkg::DATA_W-1:0] pwdata,
	output logic [hvps_pkg::DATA_W-1:0] prdata,
	output logic                        pready
);

	hvps_pkg::cfg_t    cfg;
	hvps_pkg::item_t   item_s1;
	hvps_pkg::result_t res;
	hvps_pkg::result_t res_s2;
	logic              valid_s1;
	logic              valid_s2;
	logic              advance;

	localparam int ITEM_W = $bits(hvps_pkg::item_t);
	localparam int RES_W  = $bits(hvps_pkg::result_t);

	hvps_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	hvps_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.item   (item_s1),
		.step   (advance),
		.res    (res)
	);

	assign advance  = valid_s1 & (~valid_s2 | m_tready);
	assign s_tready = ~valid_s1 | advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready)
				valid_s1 <= s_tvalid;
			if (advance)
				valid_s2 <= 1'b1;
			else if (m_tready)
				valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid)
			item_s1 <= s_tdata[ITEM_W-1:0];
		if (advance)
			res_s2 <= res;
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {{(hvps_pkg::OUT_W-RES_W){1'b0}}, res_s2};

	// both contactors are never commanded closed together
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(res_s2.drive_contactor && res_s2.precharge_contactor))
		else $error("drive and precharge contactors both closed");

	// idle always opens both contactors
	a_idle_open: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && res_s2.mode == hvps_pkg::MODE_IDLE) |->
		(!res_s2.drive_contactor && !res_s2.precharge_contactor))
		else $error("contactor closed in idle");

	// only defined modes are ever reported
	a_mode_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (res_s2.mode <= hvps_pkg::MODE_CHARGING))
		else $error("undefined mode on output");

	// a tick leaving the input register lands in the output register
	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> m_tvalid)
		else $error("advanced tick lost");

	// precharge mode implies the precharge contactor is closed
	a_pre_closed: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (res_s2.mode == hvps_pkg::MODE_PRECHARGE ||
		              res_s2.mode == hvps_pkg::MODE_CHG_PRECHARGE)) |->
		res_s2.precharge_contactor)
		else $error("precharge contactor open while precharging");

endmodule

>>> sv/hvps_cfg.sv
// ----------------------------------------------------------------------------
// hvps_cfg
// APB register file: precharge ratio and verify time.
// ----------------------------------------------------------------------------
module hvps_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [hvps_pkg::ADDR_W-1:0] paddr,
	input  logic [hvps_pkg::DATA_W-1:0] pwdata,
	output logic [hvps_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	output hvps_pkg::cfg_t              cfg
);

	logic [hvps_pkg::RATIO_W-1:0] ratio_q;
	logic [hvps_pkg::TIME_W-1:0]  verify_q;
	logic                         wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;

	// word index sits in paddr[2], byte offset is ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ratio_q  <= hvps_pkg::RATIO_RESET;
			verify_q <= hvps_pkg::VERIFY_RESET;
		end else if (wr_en) begin
			case (paddr[2])
				hvps_pkg::REG_RATIO:  ratio_q  <= pwdata[hvps_pkg::RATIO_W-1:0];
				hvps_pkg::REG_VERIFY: verify_q <= pwdata[hvps_pkg::TIME_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			hvps_pkg::REG_RATIO:
				prdata = {{(hvps_pkg::DATA_W-hvps_pkg::RATIO_W){1'b0}}, ratio_q};
			hvps_pkg::REG_VERIFY:
				prdata = {{(hvps_pkg::DATA_W-hvps_pkg::TIME_W){1'b0}}, verify_q};
			default:
				prdata = '0;
		endcase
	end

	assign cfg.precharge_ratio = ratio_q;
	assign cfg.verify_time_ms  = verify_q;

endmodule

>>> sv/hvps_ctrl.sv
// ----------------------------------------------------------------------------
// hvps_ctrl
// Mode, verify timer and contactor state with the per-tick update logic.
// ----------------------------------------------------------------------------
module hvps_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  hvps_pkg::cfg_t      cfg,
	input  hvps_pkg::item_t     item,
	input  logic                step,
	output hvps_pkg::result_t   res
);

	logic [hvps_pkg::MODE_W-1:0] mode_q, mode_d;
	logic [hvps_pkg::TIME_W-1:0] timer_q, timer_d;
	logic                        drive_q, drive_d;
	logic                        pre_q, pre_d;

	logic                        healthy;
	logic                        above;
	logic [hvps_pkg::PROD_W-1:0] lhs;
	logic [hvps_pkg::PROD_W-1:0] rhs;
	logic [hvps_pkg::TIME_W:0]   sum;
	logic [hvps_pkg::TIME_W-1:0] timer_sat;
	logic                        done;
	logic [hvps_pkg::MODE_W-1:0] done_mode;

	assign healthy = item.shutdown_closed & item.hv_ok;

	// exact threshold: vt * 1024 > ratio * vp
	assign lhs   = {item.tractive_voltage, {hvps_pkg::RATIO_W{1'b0}}};
	assign rhs   = hvps_pkg::PROD_W'(cfg.precharge_ratio) * hvps_pkg::PROD_W'(item.pack_voltage);
	assign above = lhs > rhs;

	assign sum       = {1'b0, timer_q} + {{(hvps_pkg::TIME_W+1-hvps_pkg::DELTA_W){1'b0}},
	                   item.delta_ms};
	assign timer_sat = sum[hvps_pkg::TIME_W] ? {hvps_pkg::TIME_W{1'b1}}
	                                         : sum[hvps_pkg::TIME_W-1:0];
	assign done      = timer_sat >= cfg.verify_time_ms;
	assign done_mode = (mode_q == hvps_pkg::MODE_CHG_PRECHARGE) ? hvps_pkg::MODE_CHARGING
	                                                            : hvps_pkg::MODE_ENERGIZED;

	always_comb begin
		mode_d  = mode_q;
		timer_d = timer_q;
		drive_d = drive_q;
		pre_d   = pre_q;
		case (mode_q)
			hvps_pkg::MODE_IDLE: begin
				if (healthy) begin
					timer_d = '0;
					pre_d   = 1'b1;
					mode_d  = item.charger_present ? hvps_pkg::MODE_CHG_PRECHARGE
					                               : hvps_pkg::MODE_PRECHARGE;
				end
			end
			hvps_pkg::MODE_PRECHARGE, hvps_pkg::MODE_CHG_PRECHARGE: begin
				// fault wins over the voltage check
				if (!healthy || (mode_q == hvps_pkg::MODE_CHG_PRECHARGE &&
				                 !item.charger_present)) begin
					mode_d  = hvps_pkg::MODE_IDLE;
					timer_d = '0;
					drive_d = 1'b0;
					pre_d   = 1'b0;
				end else if (above) begin
					timer_d = timer_sat;
					if (done) begin
						drive_d = 1'b1;
						pre_d   = 1'b0;
						mode_d  = done_mode;
					end
				end else begin
					timer_d = '0;
				end
			end
			hvps_pkg::MODE_ENERGIZED: begin
				if (!healthy) begin
					mode_d  = hvps_pkg::MODE_IDLE;
					timer_d = '0;
					drive_d = 1'b0;
					pre_d   = 1'b0;
				end
			end
			hvps_pkg::MODE_CHARGING: begin
				if (!healthy || !item.charger_present) begin
					mode_d  = hvps_pkg::MODE_IDLE;
					timer_d = '0;
					drive_d = 1'b0;
					pre_d   = 1'b0;
				end
			end
			default: begin
				mode_d  = hvps_pkg::MODE_IDLE;
				timer_d = '0;
				drive_d = 1'b0;
				pre_d   = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= hvps_pkg::MODE_IDLE;
			timer_q <= '0;
			drive_q <= 1'b0;
			pre_q   <= 1'b0;
		end else if (step) begin
			mode_q  <= mode_d;
			timer_q <= timer_d;
			drive_q <= drive_d;
			pre_q   <= pre_d;
		end
	end

	assign res.mode                = mode_d;
	assign res.drive_contactor     = drive_d;
	assign res.precharge_contactor = pre_d;

endmodule

>>> tb/hv_precharge_sequencer_tb.sv
// ----------------------------------------------------------------------------
// hv_precharge_sequencer_tb
// Self-checking bench for the precharge and contactor sequencer. Ticks go in
// on the input stream and each is run through a cycle-free model of the mode,
// verify timer and contactor state. Every result on the output stream is
// checked against the oldest predicted transaction. A directed sequence comes
// first, then random segments under several register settings and
// backpressure mixes, with the registers written over APB between segments.
// ----------------------------------------------------------------------------
module hv_precharge_sequencer_tb;

	timeunit 1ns;
	timeprecision 1ps;

	class tick_scoreboard;
		hvps_pkg::result_t            expected_q[$];
		logic [hvps_pkg::RATIO_W-1:0] ratio;
		logic [hvps_pkg::TIME_W-1:0]  verify_ms;
		logic [hvps_pkg::MODE_W-1:0]  mode;
		logic [hvps_pkg::TIME_W-1:0]  timer;
		logic                         drive;
		logic                         precharge;
		int                           errors;

		function new();
			ratio = hvps_pkg::RATIO_RESET;
			verify_ms = hvps_pkg::VERIFY_RESET;
			mode = hvps_pkg::MODE_IDLE;
			timer = '0;
			drive = 1'b0;
			precharge = 1'b0;
			errors = 0;
		endfunction

		function void write_reg(logic idx, logic [hvps_pkg::DATA_W-1:0] val);
			if (idx == hvps_pkg::REG_RATIO) begin
				ratio = val[hvps_pkg::RATIO_W-1:0];
			end else begin
				verify_ms = val[hvps_pkg::TIME_W-1:0];
			end
		endfunction

		function void drop_to_idle();
			mode = hvps_pkg::MODE_IDLE;
			drive = 1'b0;
			precharge = 1'b0;
			timer = '0;
		endfunction

		// healthy precharge tick: accumulate while above threshold, close drive when done
		function void precharge_step(hvps_pkg::item_t it, logic [hvps_pkg::MODE_W-1:0] done_mode);
			logic [hvps_pkg::PROD_W-1:0] lhs;
			logic [hvps_pkg::PROD_W-1:0] rhs;
			logic [hvps_pkg::TIME_W:0]   sum;
			lhs = {it.tractive_voltage, {hvps_pkg::RATIO_W{1'b0}}};
			rhs = {{hvps_pkg::VOLT_W{1'b0}}, ratio} *
				{{hvps_pkg::RATIO_W{1'b0}}, it.pack_voltage};
			if (lhs > rhs) begin
				sum = {1'b0, timer} +
					{{(hvps_pkg::TIME_W + 1 - hvps_pkg::DELTA_W){1'b0}}, it.delta_ms};
				timer = sum[hvps_pkg::TIME_W] ? '1 : sum[hvps_pkg::TIME_W-1:0];
				if (timer >= verify_ms) begin
					drive = 1'b1;
					precharge = 1'b0;
					mode = done_mode;
				end
			end else begin
				timer = '0;
			end
		endfunction

		function void note_tick(hvps_pkg::item_t it);
			logic              healthy;
			hvps_pkg::result_t r;
			healthy = it.shutdown_closed & it.hv_ok;
			case (mode)
				hvps_pkg::MODE_IDLE: begin
					if (healthy) begin
						timer = '0;
						precharge = 1'b1;
						mode = it.charger_present ? hvps_pkg::MODE_CHG_PRECHARGE
						                          : hvps_pkg::MODE_PRECHARGE;
					end
				end
				hvps_pkg::MODE_PRECHARGE: begin
					if (!healthy) drop_to_idle();
					else precharge_step(it, hvps_pkg::MODE_ENERGIZED);
				end
				hvps_pkg::MODE_ENERGIZED: begin
					if (!healthy) drop_to_idle();
				end
				hvps_pkg::MODE_CHG_PRECHARGE: begin
					if (!healthy || !it.charger_present) drop_to_idle();
					else precharge_step(it, hvps_pkg::MODE_CHARGING);
				end
				hvps_pkg::MODE_CHARGING: begin
					if (!healthy || !it.charger_present) drop_to_idle();
				end
				default: drop_to_idle();
			endcase
			r.mode = mode;
			r.drive_contactor = drive;
			r.precharge_contactor = precharge;
			expected_q.push_back(r);
		endfunction

		task report_mismatch(string msg);
			$display("%0t ns: mismatch: %s", $time, msg);
			errors++;
		endtask

		task check_result(hvps_pkg::result_t got);
			hvps_pkg::result_t want;
			if (expected_q.size() == 0) begin
				report_mismatch($sformatf("result mode %0d with no transaction pending", got.mode));
				return;
			end
			want = expected_q.pop_front();
			if (got.mode !== want.mode)
				report_mismatch($sformatf("mode got %0d want %0d", got.mode, want.mode));
			if (got.drive_contactor !== want.drive_contactor)
				report_mismatch($sformatf("drive_contactor got %b want %b",
					got.drive_contactor, want.drive_contactor));
			if (got.precharge_contactor !== want.precharge_contactor)
				report_mismatch($sformatf("precharge_contactor got %b want %b",
					got.precharge_contactor, want.precharge_contactor));
		endtask

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	localparam int STALL_LIMIT = 2000;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        s_tvalid = 1'b0;
	logic                        s_tready;
	logic [hvps_pkg::IN_W-1:0]   s_tdata = '0;
	logic                        m_tvalid;
	logic                        m_tready = 1'b0;
	logic [hvps_pkg::OUT_W-1:0]  m_tdata;
	logic                        psel = 1'b0;
	logic                        penable = 1'b0;
	logic                        pwrite = 1'b0;
	logic [hvps_pkg::ADDR_W-1:0] paddr = '0;
	logic [hvps_pkg::DATA_W-1:0] pwdata = '0;
	logic [hvps_pkg::DATA_W-1:0] prdata;
	logic                        pready;

	tick_scoreboard sb = new();

	int   send_gap_pct = 0;
	int   ready_stall_pct = 0;
	bit   calm = 1'b0;
	bit   in_took = 1'b0;
	logic cur_chg = 1'b0;
	int   quiet_cycles = 0;

	hv_precharge_sequencer u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always #5 clk = ~clk;

	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= ready_stall_pct);
	end

	// sample both streams on the edge; also the no-progress watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			in_took = s_tvalid && s_tready;
			if (in_took)
				sb.note_tick(hvps_pkg::item_t'(s_tdata[$bits(hvps_pkg::item_t)-1:0]));
			if (m_tvalid && m_tready)
				sb.check_result(hvps_pkg::result_t'(m_tdata[$bits(hvps_pkg::result_t)-1:0]));
			if (in_took || (m_tvalid && m_tready) || (psel && penable)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= STALL_LIMIT) begin
					$display("hv_precharge_sequencer_tb: FAIL");
					$finish;
				end
			end
		end
	end

	function automatic hvps_pkg::item_t mk(logic sd, logic hv, logic chg,
			logic [hvps_pkg::DELTA_W-1:0] d,
			logic [hvps_pkg::VOLT_W-1:0] vt, logic [hvps_pkg::VOLT_W-1:0] vp);
		hvps_pkg::item_t it;
		it.shutdown_closed = sd;
		it.hv_ok = hv;
		it.charger_present = chg;
		it.delta_ms = d;
		it.tractive_voltage = vt;
		it.pack_voltage = vp;
		return it;
	endfunction

	function automatic hvps_pkg::item_t rand_tick();
		hvps_pkg::item_t             it;
		logic [hvps_pkg::PROD_W-1:0] thr;
		logic [31:0]                 rnd;
		int                          pick;
		int                          above_pct;
		if ($urandom_range(99) < (calm ? 1 : 12)) begin
			rnd = $urandom_range(1);
			it.shutdown_closed = rnd[0];
			rnd = $urandom_range(1);
			it.hv_ok = it.shutdown_closed ? 1'b0 : rnd[0];
		end else begin
			it.shutdown_closed = 1'b1;
			it.hv_ok = 1'b1;
		end
		if ($urandom_range(99) < (calm ? 1 : 4))
			cur_chg = ~cur_chg;
		it.charger_present = cur_chg;
		pick = $urandom_range(99);
		if (pick < 60) rnd = $urandom;
		else if (pick < 80) rnd = '1;
		else if (pick < 90) rnd = '0;
		else rnd = $urandom_range(15);
		it.delta_ms = rnd[hvps_pkg::DELTA_W-1:0];
		pick = $urandom_range(99);
		if (pick < 60) rnd = $urandom;
		else if (pick < 70) rnd = '1;
		else if (pick < 80) rnd = $urandom & 32'h0000_FC00;
		else rnd = $urandom_range(2047);
		it.pack_voltage = rnd[hvps_pkg::VOLT_W-1:0];
		// floor of the threshold; thr itself is never above, thr + 1 always is
		thr = ({{hvps_pkg::VOLT_W{1'b0}}, sb.ratio} *
			{{hvps_pkg::RATIO_W{1'b0}}, it.pack_voltage}) >> hvps_pkg::RATIO_W;
		above_pct = calm ? 97 : 60;
		pick = $urandom_range(99);
		if (pick < above_pct) begin
			rnd = $urandom_range(65535, thr + 1);
			it.tractive_voltage = rnd[hvps_pkg::VOLT_W-1:0];
		end else if (pick < above_pct + 8) begin
			it.tractive_voltage = thr[hvps_pkg::VOLT_W-1:0];
		end else if (pick < above_pct + 15) begin
			it.tractive_voltage = thr[hvps_pkg::VOLT_W-1:0] + 1'b1;
		end else begin
			rnd = $urandom;
			it.tractive_voltage = rnd[hvps_pkg::VOLT_W-1:0];
		end
		return it;
	endfunction

	// entered and left at a falling edge; valid stays high for a back-to-back call
	task automatic send_tick(input hvps_pkg::item_t it);
		while ($urandom_range(99) < send_gap_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {{(hvps_pkg::IN_W - $bits(hvps_pkg::item_t)){1'b0}}, it};
		@(negedge clk);
		while (!in_took) @(negedge clk);
	endtask

	task automatic apb_write(input logic idx, input logic [hvps_pkg::DATA_W-1:0] val);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sb.write_reg(idx, val);
	endtask

	task automatic wait_drained();
		while (sb.pending() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// upper pwdata bits carry junk, the registers take only their width
	task automatic configure(input logic [hvps_pkg::RATIO_W-1:0] ratio,
			input logic [hvps_pkg::TIME_W-1:0] vtime,
			input int gap_pct, input int stall_pct, input bit quiet);
		logic [hvps_pkg::DATA_W-1:0] junk;
		wait_drained();
		junk = $urandom;
		apb_write(hvps_pkg::REG_RATIO, {junk[hvps_pkg::DATA_W-1:hvps_pkg::RATIO_W], ratio});
		junk = $urandom;
		apb_write(hvps_pkg::REG_VERIFY, {junk[hvps_pkg::DATA_W-1:hvps_pkg::TIME_W], vtime});
		send_gap_pct = gap_pct;
		ready_stall_pct = stall_pct;
		calm = quiet;
	endtask

	task automatic run_random(input int n);
		for (int i = 0; i < n; i++)
			send_tick(rand_tick());
		s_tvalid <= 1'b0;
	endtask

	initial begin
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: drive sequence, faults, charger loss
		send_tick(mk(0, 0, 0, 0, 0, 0));
		send_tick(mk(1, 0, 1, 1023, 65535, 65535));
		send_tick(mk(0, 1, 0, 1023, 65535, 65535));
		send_tick(mk(1, 1, 0, 0, 0, 0));
		send_tick(mk(1, 1, 0, 1023, 0, 65535));
		repeat (5) send_tick(mk(1, 1, 0, 1023, 65535, 65535));
		send_tick(mk(1, 1, 0, 1023, 0, 0));
		send_tick(mk(1, 0, 0, 1023, 65535, 65535));
		send_tick(mk(1, 1, 1, 0, 0, 0));
		send_tick(mk(1, 1, 0, 1023, 65535, 65535));
		send_tick(mk(1, 1, 1, 0, 0, 0));
		send_tick(mk(0, 1, 1, 1023, 65535, 65535));
		s_tvalid <= 1'b0;

		// zero verify time, exact threshold equality, zero pack voltage
		configure(10'd1023, 16'd0, 0, 0, 1'b0);
		send_tick(mk(1, 1, 1, 0, 0, 0));
		send_tick(mk(1, 1, 1, 0, 1023, 1024));
		send_tick(mk(1, 1, 1, 0, 1024, 1024));
		send_tick(mk(1, 1, 1, 1023, 0, 65535));
		send_tick(mk(1, 1, 0, 1023, 65535, 0));
		send_tick(mk(1, 1, 0, 0, 0, 0));
		send_tick(mk(1, 1, 0, 5, 65535, 0));
		send_tick(mk(0, 0, 1, 1023, 65535, 65535));
		s_tvalid <= 1'b0;

		configure(10'd850, 16'd5000, 0, 0, 1'b0);
		run_random(75);
		configure(10'd0, 16'd0, 49, 0, 1'b0);
		run_random(75);
		configure(10'd1023, 16'd65535, 0, 49, 1'b1);
		run_random(130);
		configure(10'($urandom), 16'($urandom_range(3000)), 18, 18, 1'b0);
		run_random(75);
		configure(10'd1023, 16'd0, 0, 0, 1'b0);
		run_random(75);
		configure(10'd0, 16'd65535, 49, 0, 1'b1);
		run_random(130);
		configure(10'($urandom), 16'($urandom_range(8000)), 0, 49, 1'b0);
		run_random(75);
		configure(10'($urandom), 16'($urandom), 18, 18, 1'b0);
		run_random(75);

		wait_drained();
		repeat (10) @(negedge clk);
		if (sb.pending() != 0)
			sb.report_mismatch($sformatf("%0d transactions never produced a result",
				sb.pending()));
		if (sb.errors == 0) begin
			$display("hv_precharge_sequencer_tb: PASS");
		end else begin
			$display("hv_precharge_sequencer_tb: FAIL");
		end
		$finish;
	end

endmodule
